[sv/drw_pkg.sv]
// shared types, constants and helper functions of the damped random walk generator
package drw_pkg;

  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam logic [32:0] K_Q32     = 33'd5707029011;
  localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;
  localparam int          CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_SIGMA   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_TAU = 1'd1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_S_MUL, ST_S_RND, ST_D_MUL, ST_D_CHK,
    ST_X_ENT, ST_X_K, ST_X_T1, ST_X_M1, ST_X_M2, ST_X_M3, ST_X_FIN,
    ST_SQ, ST_SQ_WAIT, ST_A_MUL, ST_A_GET, ST_N_LO, ST_N_HI, ST_DEC, ST_M_RND,
    ST_F_MUL, ST_F_Z, ST_F_XM, ST_F_XG, ST_F_OUT
  } st_t;

  typedef enum logic [1:0] {RET_E1, RET_E2, RET_G} ret_t;

  typedef struct packed {
    logic signed [23:0] mag;
    logic               sat;
  } mag_res_t;

  // floor(2^32 / n) for the series terms
  function automatic logic [31:0] recip_q32(input logic [3:0] n);
    logic [31:0] r;
    unique case (n)
      4'd2:    r = 32'd2147483648;
      4'd3:    r = 32'd1431655765;
      4'd4:    r = 32'd1073741824;
      4'd5:    r = 32'd858993459;
      4'd6:    r = 32'd715827882;
      4'd7:    r = 32'd613566756;
      4'd8:    r = 32'd536870912;
      4'd9:    r = 32'd477218588;
      4'd10:   r = 32'd429496729;
      4'd11:   r = 32'd390451572;
      4'd12:   r = 32'd357913941;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // round half away from zero, then clamp to 24 bit signed
  function automatic mag_res_t mag_rnd(input logic signed [63:0] v, input logic [5:0] sh);
    mag_res_t   res;
    logic       neg;
    logic [63:0] av;
    logic [63:0] half;
    logic [63:0] q;
    logic [63:0] nq;
    neg  = v[63];
    av   = neg ? 64'(-v) : 64'(v);
    half = 64'd1 << (sh - 6'd1);
    q    = (av + half) >> sh;
    nq   = 64'(-q);
    res.sat = 1'b0;
    if (!neg && q > 64'd8388607) begin
      res.mag = 24'sh7FFFFF;
      res.sat = 1'b1;
    end else if (neg && q > 64'd8388608) begin
      res.mag = 24'sh800000;
      res.sat = 1'b1;
    end else if (neg) begin
      res.mag = $signed(nq[23:0]);
    end else begin
      res.mag = $signed(q[23:0]);
    end
    return res;
  endfunction

endpackage

[sv/drw_mul.sv]
// shared signed multiplier with registered product
module drw_mul (
  input  logic               clk,
  input  logic signed [32:0] op_a,
  input  logic signed [33:0] op_b,
  output logic signed [66:0] prod_r
);
  logic signed [66:0] prod_nxt;

  assign prod_nxt = 67'(op_a) * 67'(op_b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end
endmodule

[sv/drw_sqrt.sv]
// iterative integer square root, one result bit per cycle
module drw_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [62:0] val,
  output logic        done_r,
  output logic [31:0] root
);
  logic [63:0] v_r, v_nxt;
  logic [63:0] res_r, res_nxt;
  logic [63:0] bit_r, bit_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_nxt;
  logic [63:0] trial;

  assign root  = res_r[31:0];
  assign trial = res_r + bit_r;

  always_comb begin
    v_nxt    = v_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      v_nxt    = {1'b0, val};
      res_nxt  = '0;
      bit_nxt  = 64'd1 << 62;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (v_r >= trial) begin
        v_nxt   = v_r - trial;
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    v_r   <= v_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end
endmodule

[sv/damped_random_walk_sample_gen.sv]
// top level: damped random walk magnitude and flux generator
//
//  channel | ports                                         | dir
//  --------+-----------------------------------------------+----
//  in      | in_valid in_stall in_start_req in_sample_time | in
//          | in_normal_draw                                |
//  out     | out_valid out_stall out_magnitude out_flux    | out
//          | out_saturated                                 |
//  cfg     | cfg_we cfg_idx cfg_wdata                      | in
//
// one transaction at a time; in_stall is high from acceptance until the result is loaded
// curve start and repeated time skip the decay and noise path; a normal step runs it in full
// products use the shared multiplier; each exp series term steps through X_M1, X_M2, X_M3,
// and a normal step runs up to three exponentials plus the iterative square root
// out register decouples the sides: a new transaction is taken while a result waits
// rst_n is synchronous; it restores sigma = inv_tau = 1.0 and clears the walk history
module damped_random_walk_sample_gen (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [drw_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [31:0]                    cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_start_req,
  input  logic [31:0]                    in_sample_time,
  input  logic signed [15:0]             in_normal_draw,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [23:0]             out_magnitude,
  output logic [31:0]                    out_flux,
  output logic                           out_saturated
);
  import drw_pkg::*;

  // sequencer state
  st_t  st_r, st_nxt;
  ret_t ret_r, ret_nxt;

  // configuration and walk history
  logic [23:0]        sigma_r, sigma_nxt;
  logic [31:0]        inv_tau_r, inv_tau_nxt;
  logic [31:0]        last_time_r, last_time_nxt;
  logic signed [23:0] last_mag_r, last_mag_nxt;
  logic               have_last_r, have_last_nxt;

  // current transaction
  logic [31:0]        t_r, t_nxt;
  logic signed [15:0] draw_r, draw_nxt;
  logic               upd_time_r, upd_time_nxt;

  // exp series working registers
  logic [37:0]        x_r, x_nxt;
  logic [36:0]        d_r, d_nxt;
  logic [5:0]         k_r, k_nxt;
  logic [2:0]         j_r, j_nxt;
  logic [3:0]         n_r, n_nxt;
  logic [31:0]        term_r, term_nxt;
  logic [31:0]        p_r, p_nxt;
  logic signed [34:0] sum_r, sum_nxt;
  logic [32:0]        e1_r, e1_nxt;
  logic [32:0]        e2_r, e2_nxt;
  logic [32:0]        g_r, g_nxt;

  // noise / magnitude / flux
  logic [38:0]        a_r, a_nxt;
  logic signed [63:0] noise_r, noise_nxt;
  logic signed [23:0] mag_r, mag_nxt;
  logic               msat_r, msat_nxt;
  logic signed [10:0] fn_r, fn_nxt;
  logic [31:0]        f_r, f_nxt;

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic signed [23:0] out_mag_r, out_mag_nxt;
  logic [31:0]        out_flux_r, out_flux_nxt;
  logic               out_sat_r, out_sat_nxt;

  // shared units
  logic signed [32:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [66:0] prod_r;
  logic               sq_start;
  logic [62:0]        sq_val;
  logic               sq_done;
  logic [31:0]        sq_root;

  // helpers
  logic [37:0]        ln2_sh;
  logic [35:0]        qn;
  logic [35:0]        rem;
  logic [31:0]        q0;
  logic [31:0]        q;
  logic [32:0]        x_res;
  logic [63:0]        uz;
  logic signed [10:0] nr;
  logic [10:0]        neg_nr;
  logic [63:0]        fv;
  logic               fsat;
  mag_res_t           mres;
  logic               in_acc;
  logic               out_free;

  drw_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod_r)
  );

  drw_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (sq_start),
    .val    (sq_val),
    .done_r (sq_done),
    .root   (sq_root)
  );

  assign in_stall      = (st_r != ST_IDLE);
  assign in_acc        = in_valid && !in_stall;
  assign out_valid     = out_valid_r;
  assign out_magnitude = out_mag_r;
  assign out_flux      = out_flux_r;
  assign out_saturated = out_sat_r;
  assign out_free      = !out_valid_r || !out_stall;

  assign sq_start = (st_r == ST_SQ);
  assign sq_val   = {ONE_Q32 - e2_r, 30'd0};

  // range reduction step and series division correction
  assign ln2_sh = {6'd0, LN2_Q32} << j_r;
  assign q0     = prod_r[63:32];
  assign qn     = {4'd0, q0} * {32'd0, n_r};
  assign rem    = {4'd0, p_r} - qn;
  assign q      = (rem >= {32'd0, n_r}) ? q0 + 32'd1 : q0;
  assign x_res  = sum_r[32:0] >> k_r;

  // mag * K offset so the integer part is non-negative
  assign uz = 64'(prod_r[63:0]) + (64'd1 << 56);

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (st_r)
      ST_S_MUL: begin
        mul_a = {9'd0, sigma_r};
        mul_b = 34'(draw_r);
      end
      ST_D_MUL: begin
        mul_a = {1'b0, t_r - last_time_r};
        mul_b = {2'b0, inv_tau_r};
      end
      ST_X_M1: begin
        mul_a = {1'b0, term_r};
        mul_b = {2'b0, x_r[31:0]};
      end
      ST_X_M2: begin
        mul_a = {1'b0, prod_r[63:32]};
        mul_b = {2'b0, recip_q32(n_r)};
      end
      ST_A_MUL: begin
        mul_a = {9'd0, sigma_r};
        mul_b = {2'b0, sq_root};
      end
      ST_N_LO: begin
        mul_a = 33'(draw_r);
        mul_b = {2'b0, a_r[31:0]};
      end
      ST_N_HI: begin
        mul_a = 33'(draw_r);
        mul_b = {27'd0, a_r[38:32]};
      end
      ST_DEC: begin
        mul_a = 33'(last_mag_r);
        mul_b = {1'b0, e1_r};
      end
      ST_F_MUL: begin
        mul_a = 33'(mag_r);
        mul_b = {1'b0, K_Q32};
      end
      ST_F_XM: begin
        mul_a = {1'b0, f_r};
        mul_b = {2'b0, LN2_Q32};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // flux = g * 2^-(n+16) with rounding and clamp
  always_comb begin
    nr     = fn_r + 11'sd16;
    neg_nr = 11'(-nr);
    fv     = '0;
    fsat   = 1'b0;
    if (nr < 0) begin
      if (neg_nr >= 11'd32) begin
        fsat = 1'b1;
      end else begin
        fv = {31'd0, g_r} << neg_nr[4:0];
      end
    end else if (nr == 0) begin
      fv = {31'd0, g_r};
    end else if (nr >= 11'sd64) begin
      fv = '0;
    end else begin
      fv = ({31'd0, g_r} + (64'd1 << (nr[5:0] - 6'd1))) >> nr[5:0];
    end
    if (fv[63:32] != 32'd0) begin
      fsat = 1'b1;
    end
  end

  // sequencer
  always_comb begin
    st_nxt        = st_r;
    ret_nxt       = ret_r;
    sigma_nxt     = sigma_r;
    inv_tau_nxt   = inv_tau_r;
    last_time_nxt = last_time_r;
    last_mag_nxt  = last_mag_r;
    have_last_nxt = have_last_r;
    t_nxt         = t_r;
    draw_nxt      = draw_r;
    upd_time_nxt  = upd_time_r;
    x_nxt         = x_r;
    d_nxt         = d_r;
    k_nxt         = k_r;
    j_nxt         = j_r;
    n_nxt         = n_r;
    term_nxt      = term_r;
    p_nxt         = p_r;
    sum_nxt       = sum_r;
    e1_nxt        = e1_r;
    e2_nxt        = e2_r;
    g_nxt         = g_r;
    a_nxt         = a_r;
    noise_nxt     = noise_r;
    mag_nxt       = mag_r;
    msat_nxt      = msat_r;
    fn_nxt        = fn_r;
    f_nxt         = f_r;
    out_valid_nxt = out_valid_r;
    out_mag_nxt   = out_mag_r;
    out_flux_nxt  = out_flux_r;
    out_sat_nxt   = out_sat_r;
    mres          = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_SIGMA:   sigma_nxt   = cfg_wdata[23:0];
        CFG_INV_TAU: inv_tau_nxt = cfg_wdata;
        default:     sigma_nxt   = sigma_r;
      endcase
    end

    unique case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          t_nxt    = in_sample_time;
          draw_nxt = in_normal_draw;
          if (in_start_req || !have_last_r) begin
            upd_time_nxt = 1'b1;
            st_nxt       = ST_S_MUL;
          end else if (in_sample_time <= last_time_r) begin
            // time not ascending: hold the last value
            upd_time_nxt = 1'b0;
            mag_nxt      = last_mag_r;
            msat_nxt     = 1'b0;
            st_nxt       = ST_F_MUL;
          end else begin
            upd_time_nxt = 1'b1;
            st_nxt       = ST_D_MUL;
          end
        end
      end
      ST_S_MUL: st_nxt = ST_S_RND;
      ST_S_RND: begin
        mres     = mag_rnd(prod_r[63:0], 6'd12);
        mag_nxt  = mres.mag;
        msat_nxt = mres.sat;
        st_nxt   = ST_F_MUL;
      end
      ST_D_MUL: st_nxt = ST_D_CHK;
      ST_D_CHK: begin
        if (prod_r[63:37] != '0) begin
          e1_nxt = '0;
          e2_nxt = '0;
          st_nxt = ST_SQ;
        end else begin
          d_nxt   = prod_r[36:0];
          x_nxt   = {1'b0, prod_r[36:0]};
          ret_nxt = RET_E1;
          st_nxt  = ST_X_ENT;
        end
      end
      ST_X_ENT: begin
        k_nxt = '0;
        if (x_r[37]) begin
          // argument at or beyond 32: result is zero
          sum_nxt = '0;
          st_nxt  = ST_X_FIN;
        end else begin
          j_nxt  = 3'd5;
          st_nxt = ST_X_K;
        end
      end
      ST_X_K: begin
        if (x_r >= ln2_sh) begin
          x_nxt      = x_r - ln2_sh;
          k_nxt[j_r] = 1'b1;
        end
        if (j_r == 3'd0) begin
          st_nxt = ST_X_T1;
        end else begin
          j_nxt = j_r - 3'd1;
        end
      end
      ST_X_T1: begin
        term_nxt = x_r[31:0];
        sum_nxt  = $signed({2'b0, ONE_Q32}) - $signed({3'b0, x_r[31:0]});
        n_nxt    = 4'd2;
        st_nxt   = ST_X_M1;
      end
      ST_X_M1: st_nxt = ST_X_M2;
      ST_X_M2: begin
        p_nxt  = prod_r[63:32];
        st_nxt = ST_X_M3;
      end
      ST_X_M3: begin
        term_nxt = q;
        if (n_r[0]) begin
          sum_nxt = sum_r - $signed({3'b0, q});
        end else begin
          sum_nxt = sum_r + $signed({3'b0, q});
        end
        if (n_r == 4'd12) begin
          st_nxt = ST_X_FIN;
        end else begin
          n_nxt  = n_r + 4'd1;
          st_nxt = ST_X_M1;
        end
      end
      ST_X_FIN: begin
        unique case (ret_r)
          RET_E1: begin
            e1_nxt  = x_res;
            x_nxt   = {d_r, 1'b0};
            ret_nxt = RET_E2;
            st_nxt  = ST_X_ENT;
          end
          RET_E2: begin
            e2_nxt = x_res;
            st_nxt = ST_SQ;
          end
          RET_G: begin
            g_nxt  = x_res;
            st_nxt = ST_F_OUT;
          end
          default: st_nxt = ST_IDLE;
        endcase
      end
      ST_SQ:      st_nxt = ST_SQ_WAIT;
      ST_SQ_WAIT: begin
        if (sq_done) begin
          st_nxt = ST_A_MUL;
        end
      end
      ST_A_MUL: st_nxt = ST_A_GET;
      ST_A_GET: begin
        a_nxt  = prod_r[54:16];
        st_nxt = ST_N_LO;
      end
      ST_N_LO: st_nxt = ST_N_HI;
      ST_N_HI: begin
        noise_nxt = prod_r[63:0];
        st_nxt    = ST_DEC;
      end
      ST_DEC: begin
        noise_nxt = ((prod_r[63:0] <<< 32) + noise_r) <<< 5;
        st_nxt    = ST_M_RND;
      end
      ST_M_RND: begin
        mres     = mag_rnd(prod_r[63:0] + noise_r, 6'd32);
        mag_nxt  = mres.mag;
        msat_nxt = mres.sat;
        st_nxt   = ST_F_MUL;
      end
      ST_F_MUL: st_nxt = ST_F_Z;
      ST_F_Z: begin
        fn_nxt = $signed({1'b0, uz[57:48]}) - 11'sd256;
        f_nxt  = uz[47:16];
        st_nxt = ST_F_XM;
      end
      ST_F_XM: st_nxt = ST_F_XG;
      ST_F_XG: begin
        x_nxt   = {6'd0, prod_r[63:32]};
        ret_nxt = RET_G;
        st_nxt  = ST_X_ENT;
      end
      ST_F_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_mag_nxt   = mag_r;
          out_flux_nxt  = fsat ? 32'hFFFF_FFFF : fv[31:0];
          out_sat_nxt   = msat_r || fsat;
          last_mag_nxt  = mag_r;
          have_last_nxt = 1'b1;
          if (upd_time_r) begin
            last_time_nxt = t_r;
          end
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    t_r        <= t_nxt;
    draw_r     <= draw_nxt;
    upd_time_r <= upd_time_nxt;
    x_r        <= x_nxt;
    d_r        <= d_nxt;
    k_r        <= k_nxt;
    j_r        <= j_nxt;
    n_r        <= n_nxt;
    term_r     <= term_nxt;
    p_r        <= p_nxt;
    sum_r      <= sum_nxt;
    e1_r       <= e1_nxt;
    e2_r       <= e2_nxt;
    g_r        <= g_nxt;
    a_r        <= a_nxt;
    noise_r    <= noise_nxt;
    mag_r      <= mag_nxt;
    msat_r     <= msat_nxt;
    fn_r       <= fn_nxt;
    f_r        <= f_nxt;
    out_mag_r  <= out_mag_nxt;
    out_flux_r <= out_flux_nxt;
    out_sat_r  <= out_sat_nxt;
    ret_r      <= ret_nxt;
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      sigma_r     <= 24'd65536;
      inv_tau_r   <= 32'd65536;
      last_time_r <= '0;
      last_mag_r  <= '0;
      have_last_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      sigma_r     <= sigma_nxt;
      inv_tau_r   <= inv_tau_nxt;
      last_time_r <= last_time_nxt;
      last_mag_r  <= last_mag_nxt;
      have_last_r <= have_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule

[test/damped_random_walk_sample_gen_tb.sv]
// testbench for the damped random walk magnitude and flux generator
`timescale 1ns / 100ps

module damped_random_walk_sample_gen_tb;
  import drw_pkg::*;

  localparam longint unsigned LN2_C   = 64'd2977044472;
  localparam longint unsigned KFLUX_C = 64'd5707029011;
  localparam longint unsigned UNITY_C = 64'h1_0000_0000;
  localparam longint unsigned XLIM_C  = 64'd32 << 32;
  localparam int WDOG_LIMIT = 4000;
  localparam int HOLD_LEN   = 500;
  localparam int RAND_PER_PHASE = 500;

  typedef struct packed {
    logic signed [23:0] mag;
    logic [31:0]        flux;
    logic               sat;
  } walk_res_t;

  typedef struct {
    logic [23:0]        sig;
    logic [31:0]        itau;
    logic               start;
    logic [31:0]        t;
    logic signed [15:0] drw;
    logic               typed;
    walk_res_t          res;
  } vec_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [31:0] cfg_wdata;
  logic in_valid, in_stall, in_start_req;
  logic [31:0] in_sample_time;
  logic signed [15:0] in_normal_draw;
  logic out_valid, out_stall, out_saturated;
  logic signed [23:0] out_magnitude;
  logic [31:0] out_flux;

  damped_random_walk_sample_gen dut (.*);

  // predictor copy of registers and walk history
  logic [23:0]        p_sigma;
  logic [31:0]        p_inv_tau;
  logic [31:0]        p_last_t;
  logic signed [23:0] p_last_m;
  logic               p_have;

  walk_res_t pending_q[$];
  int  mismatches;
  int  idle_cycles;
  bit  quiet;          // no idling on either side
  bit  hold_req;       // ask the receiver for a long hold-off
  vec_t dir_tbl[$];

  // exp(-x), x in Q32.32, result Q.32
  function automatic longint unsigned exp_q32(longint unsigned x);
    longint unsigned k, r, term;
    longint acc;
    if (x >= XLIM_C) return 0;
    k = x / LN2_C;
    r = x - k * LN2_C;
    acc = longint'(UNITY_C);
    term = UNITY_C;
    for (int n = 1; n <= 12; n++) begin
      term = ((term * r) >> 32) / n;
      if (n % 2 == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    if (k >= 64) return 0;
    return longint'(unsigned'(acc)) >> k;
  endfunction

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // round half away from zero
  function automatic longint rnd_shift(longint v, int sh);
    longint unsigned half, u;
    half = 64'd1 << (sh - 1);
    if (v >= 0) begin
      u = (longint'(unsigned'(v)) + half) >> sh;
      return longint'(u);
    end
    u = (longint'(unsigned'(-v)) + half) >> sh;
    return -longint'(u);
  endfunction

  function automatic longint clamp24(longint v, ref bit sat);
    if (v > 8388607) begin
      sat = 1;
      return 8388607;
    end
    if (v < -8388608) begin
      sat = 1;
      return -8388608;
    end
    return v;
  endfunction

  // 10^(-0.4 m) as 2^(-K m), Q16.16
  function automatic logic [31:0] flux_of(longint m, ref bit sat);
    longint z, ex, sh;
    longint unsigned uz, fr, g, v;
    z = m * longint'(KFLUX_C);
    uz = longint'(unsigned'(z)) + (64'd1 << 56);
    ex = longint'(uz >> 48) - 256;
    fr = uz & ((64'd1 << 48) - 1);
    g = exp_q32(((fr >> 16) * LN2_C) >> 32);
    sh = 16 + ex;
    if (sh < 0) begin
      if (-sh >= 32) begin
        sat = 1;
        return 32'hFFFF_FFFF;
      end
      v = g << (-sh);
    end else if (sh == 0) begin
      v = g;
    end else if (sh >= 64) begin
      v = 0;
    end else begin
      v = (g + (64'd1 << (sh - 1))) >> sh;
    end
    if (v > 64'hFFFF_FFFF) begin
      sat = 1;
      return 32'hFFFF_FFFF;
    end
    return v[31:0];
  endfunction

  // one walk step; updates the predictor history
  function automatic walk_res_t walk_step(logic start, logic [31:0] t, logic signed [15:0] drw);
    walk_res_t o;
    bit sat;
    longint m, noise, decay;
    longint unsigned d, e1, e2, s, a;
    sat = 0;
    if (start || !p_have) begin
      m = clamp24(rnd_shift(longint'(p_sigma) * longint'(drw), 12), sat);
      p_last_t = t;
    end else if (t <= p_last_t) begin
      m = longint'(p_last_m);
    end else begin
      d = longint'(unsigned'(32'(t - p_last_t))) * longint'(unsigned'(p_inv_tau));
      e1 = 0;
      e2 = 0;
      if (d < XLIM_C) begin
        e1 = exp_q32(d);
        e2 = exp_q32(d * 2);
      end
      s = isqrt((UNITY_C - e2) << 30);
      a = (longint'(unsigned'(p_sigma)) * s) >> 16;
      noise = longint'(a) * longint'(drw) * 32;
      decay = longint'(p_last_m) * longint'(e1);
      m = clamp24(rnd_shift(decay + noise, 32), sat);
      p_last_t = t;
    end
    p_last_m = m[23:0];
    p_have = 1;
    o.flux = flux_of(m, sat);
    o.mag = m[23:0];
    o.sat = sat;
    return o;
  endfunction

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // offer one transaction and wait until it is taken
  task automatic send_item(logic start, logic [31:0] t, logic signed [15:0] drw,
                           logic typed, walk_res_t want);
    walk_res_t got;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1;
    in_start_req <= start;
    in_sample_time <= t;
    in_normal_draw <= drw;
    do @(posedge clk); while (in_stall);
    got = walk_step(start, t, drw);
    pending_q = {pending_q, (typed ? want : got)};
    @(negedge clk);
  endtask

  // registers change only with nothing in flight
  task automatic write_regs(logic [23:0] sig, logic [31:0] itau);
    in_valid <= 0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    cfg_we <= 1;
    cfg_idx <= CFG_SIGMA;
    cfg_wdata <= {8'd0, sig};
    @(negedge clk);
    cfg_idx <= CFG_INV_TAU;
    cfg_wdata <= itau;
    @(negedge clk);
    cfg_we <= 0;
    p_sigma = sig;
    p_inv_tau = itau;
  endtask

  task automatic add_row(logic [23:0] sig, logic [31:0] itau, logic start, logic [31:0] t,
                         logic signed [15:0] drw, logic typed, walk_res_t want);
    vec_t v;
    v.sig = sig; v.itau = itau; v.start = start; v.t = t; v.drw = drw;
    v.typed = typed; v.res = want;
    dir_tbl = {dir_tbl, v};
  endtask

  // receiver: random stall bursts, plus one long hold-off on request
  int stall_left;
  initial begin
    out_stall = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        stall_left = HOLD_LEN;
      end else if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 6);
      end
      if (stall_left > 0) begin
        out_stall <= 1;
        stall_left--;
      end else begin
        out_stall <= 0;
      end
    end
  end

  // result checking against the oldest expectation
  always @(posedge clk) begin
    walk_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction: mag %0d flux %h sat %0b",
                   out_magnitude, out_flux, out_saturated);
      end else begin
        want = pending_q.pop_front();
        if (want.mag !== out_magnitude || want.flux !== out_flux ||
            want.sat !== out_saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp mag %0d flux %h sat %0b, got mag %0d flux %h sat %0b",
                     want.mag, want.flux, want.sat, out_magnitude, out_flux, out_saturated);
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [31:0] cur_t;
    logic [31:0] t;
    logic        st;
    logic signed [15:0] drw;
    int sel;
    walk_res_t none;
    none = '0;
    mismatches = 0;
    idle_cycles = 0;
    quiet = 0;
    hold_req = 0;
    rst_n = 0;
    cfg_we = 0;
    cfg_idx = CFG_SIGMA;
    cfg_wdata = 0;
    in_valid = 0;
    in_start_req = 0;
    in_sample_time = 0;
    in_normal_draw = 0;
    p_sigma = 24'd65536;
    p_inv_tau = 32'd65536;
    p_last_t = 0;
    p_last_m = 0;
    p_have = 0;
    repeat (8) @(negedge clk);
    rst_n = 1;

    // directed rows: no history, repeated and earlier time, extremes of all fields
    add_row(24'd65536, 32'd65536, 0, 32'h10000, 16'sd0, 1, '{24'sd0, 32'd65536, 1'b0});
    add_row(24'd65536, 32'd65536, 0, 32'h10000, 16'sd1234, 1, '{24'sd0, 32'd65536, 1'b0});
    add_row(24'd65536, 32'd65536, 0, 32'h08000, -16'sd77, 1, '{24'sd0, 32'd65536, 1'b0});
    add_row(24'd65536, 32'd65536, 0, 32'h20000, 16'sd32767, 0, none);
    add_row(24'd65536, 32'd65536, 0, 32'h20001, -16'sd32768, 0, none);
    add_row(24'd65536, 32'd65536, 0, 32'hFFFFFFFF, 16'sd100, 0, none);
    add_row(24'd65536, 32'd65536, 1, 32'h0, 16'sd32767, 0, none);
    add_row(24'd65536, 32'd65536, 1, 32'hFFFFFFFF, -16'sd1, 0, none);
    add_row(24'hFFFFFF, 32'hFFFFFFFF, 1, 32'h0, -16'sd32768, 1,
            '{-24'sd8388608, 32'hFFFFFFFF, 1'b1});
    add_row(24'hFFFFFF, 32'hFFFFFFFF, 1, 32'h0, 16'sd32767, 1,
            '{24'sd8388607, 32'd0, 1'b1});
    add_row(24'hFFFFFF, 32'hFFFFFFFF, 0, 32'h1, 16'sd0, 0, none);
    add_row(24'hFFFFFF, 32'hFFFFFFFF, 0, 32'h2, 16'sd32767, 0, none);
    add_row(24'hFFFFFF, 32'hFFFFFFFF, 0, 32'h2, 16'sd5, 0, none);
    add_row(24'd1, 32'd1, 1, 32'h5, 16'sd32767, 0, none);
    add_row(24'd1, 32'd1, 0, 32'h6, -16'sd32768, 0, none);
    add_row(24'd1, 32'd1, 0, 32'h80000000, 16'sd5, 0, none);
    add_row(24'd1, 32'd1, 0, 32'h7FFFFFFF, 16'sd5, 0, none);

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].sig != p_sigma || dir_tbl[i].itau != p_inv_tau)
        write_regs(dir_tbl[i].sig, dir_tbl[i].itau);
      send_item(dir_tbl[i].start, dir_tbl[i].t, dir_tbl[i].drw, dir_tbl[i].typed,
                dir_tbl[i].res);
    end

    // random walks under several register settings
    cur_t = 0;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_regs(24'd65536, 32'd65536);
        1: write_regs(24'hFFFFFF, 32'hFFFFFFFF);
        2: write_regs(24'd1, 32'd1);
        default: write_regs($urandom_range(1, 24'hFFFFFF), $urandom_range(1, 32'hFFFFFFFF));
      endcase
      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        if (ph == 1 && i == 50) hold_req = 1;
        if (ph == 3 && i == RAND_PER_PHASE - 150) quiet = 1;
        sel = $urandom_range(0, 99);
        st = 0;
        if (sel < 4) begin
          st = 1;
          cur_t = $urandom();
        end else if (sel < 8) begin
          st = 1;
        end else if (sel < 13) begin
          // repeated time
        end else if (sel < 17) begin
          t = cur_t - $urandom_range(0, 32'h40000);
          cur_t = (t > cur_t) ? cur_t : t;
        end else if (sel < 20) begin
          cur_t = cur_t + $urandom_range(1, 32'h10000000);
        end else begin
          cur_t = cur_t + $urandom_range(1, 32'h40000);
        end
        if (cur_t > 32'hF0000000 && sel >= 8) begin
          st = 1;
          cur_t = $urandom_range(0, 32'hFFFF);
        end
        t = (sel >= 13 && sel < 17) ? cur_t : cur_t;
        sel = $urandom_range(0, 19);
        drw = (sel == 0) ? -16'sd32768 : (sel == 1) ? 16'sd32767 : 16'($urandom());
        send_item(st, cur_t, drw, 0, none);
      end
    end

    in_valid <= 0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/drw_pkg.sv
sv/drw_mul.sv
sv/drw_sqrt.sv
sv/damped_random_walk_sample_gen.sv
test/damped_random_walk_sample_gen_tb.sv
